/* sv/ppmfg_pkg.sv */
// ppmfg_pkg: shared constants for the ppm frame generator
// register map, command codes and reset values; no dependencies
package ppmfg_pkg;

    localparam int VALUE_W    = 16;
    localparam int CH_IN_W    = 3;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // command codes of an input request
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // register indexes, byte address is 4 * index
    localparam logic [1:0] REG_FRAME_LENGTH = 2'd0;
    localparam logic [1:0] REG_MIN_WIDTH    = 2'd1;
    localparam logic [1:0] REG_MAX_WIDTH    = 2'd2;
    localparam logic [1:0] REG_PAUSE_WIDTH  = 2'd3;

    localparam logic [VALUE_W-1:0] RESET_FRAME_LENGTH = 16'd22500;
    localparam logic [VALUE_W-1:0] RESET_MIN_WIDTH    = 16'd700;
    localparam logic [VALUE_W-1:0] RESET_MAX_WIDTH    = 16'd1700;
    localparam logic [VALUE_W-1:0] RESET_PAUSE_WIDTH  = 16'd300;

    typedef struct packed {
        logic [VALUE_W-1:0] frame_length;
        logic [VALUE_W-1:0] min_width;
        logic [VALUE_W-1:0] max_width;
        logic [VALUE_W-1:0] pause_width;
    } ppmfg_cfg_t;

endpackage

/* sv/ppmfg_ram.sv */
// ppmfg_ram: generic ram, one write port and two registered read ports
// no dependencies
module ppmfg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re_a,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
    output logic [WIDTH-1:0]                         rdata_a,
    input  logic                                     re_b,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
    output logic [WIDTH-1:0]                         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re_a)
        begin
            rdata_a <= mem[raddr_a];
        end
        if (re_b)
        begin
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

/* sv/ppm_frame_generator_core.sv */
// ppm_frame_generator_core: rc ppm pulse train generator, top level
// a request is registered in the input register at acceptance, its result in the result register
// throughput: one request per cycle unless out_ready stalls, set by the single slot-update path
// reset: config registers, slot state and channel store valid bits reset at once (async, low);
// channel entries never written read as the reset pause width, so no clearing pass is needed
// depends on ppmfg_pkg and ppmfg_ram
module ppm_frame_generator_core
    import ppmfg_pkg::*;
#(
    parameter int CHANNELS = 8
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // request channel
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  cmd,
    input  logic [CH_IN_W-1:0]                    channel,
    input  logic [VALUE_W-1:0]                    value,
    // result channel
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  pin_level,
    output logic [$clog2(2*CHANNELS+2)-1:0]       slot_index,
    output logic                                  slot_start,
    output logic                                  sync_short,
    // apb config port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [APB_ADDR_W-1:0]                 paddr,
    input  logic [APB_DATA_W-1:0]                 pwdata,
    output logic [APB_DATA_W-1:0]                 prdata,
    output logic                                  pready
);

    localparam int SLOT_W = $clog2(2*CHANNELS+2);
    localparam int IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SUM_W  = VALUE_W + $clog2(CHANNELS);
    localparam int USED_W = SUM_W + 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(2*CHANNELS + 1);

    // ---------------- configuration ----------------
    ppmfg_cfg_t cfg_reg;
    logic       cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_length <= RESET_FRAME_LENGTH;
            cfg_reg.min_width    <= RESET_MIN_WIDTH;
            cfg_reg.max_width    <= RESET_MAX_WIDTH;
            cfg_reg.pause_width  <= RESET_PAUSE_WIDTH;
        end
        else if (cfg_we)
        begin
            case (paddr[3:2])
                REG_FRAME_LENGTH: cfg_reg.frame_length <= pwdata[VALUE_W-1:0];
                REG_MIN_WIDTH:    cfg_reg.min_width    <= pwdata[VALUE_W-1:0];
                REG_MAX_WIDTH:    cfg_reg.max_width    <= pwdata[VALUE_W-1:0];
                REG_PAUSE_WIDTH:  cfg_reg.pause_width  <= pwdata[VALUE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_FRAME_LENGTH: prdata = APB_DATA_W'(cfg_reg.frame_length);
            REG_MIN_WIDTH:    prdata = APB_DATA_W'(cfg_reg.min_width);
            REG_MAX_WIDTH:    prdata = APB_DATA_W'(cfg_reg.max_width);
            REG_PAUSE_WIDTH:  prdata = APB_DATA_W'(cfg_reg.pause_width);
            default:          prdata = '0;
        endcase
    end

    // ---------------- handshake ----------------
    logic               s1_valid_reg;
    logic               s1_cmd_reg;
    logic               s1_inrange_reg;
    logic [IDX_W-1:0]   s1_addr_reg;
    logic [VALUE_W-1:0] s1_value_reg;
    logic               s1_adv;
    logic               in_accept;
    logic               out_valid_reg;

    assign s1_adv    = s1_valid_reg & (~out_valid_reg | out_ready);
    assign in_ready  = ~s1_valid_reg | s1_adv;
    assign in_accept = in_valid & in_ready;

    // request channel index, out-of-range writes are dropped later
    logic [4:0]       ch_wide;
    logic             ch_inrange;
    logic [IDX_W-1:0] ch_addr;

    assign ch_wide    = 5'(channel);
    assign ch_inrange = ch_wide < 5'(CHANNELS);
    assign ch_addr    = ch_inrange ? ch_wide[IDX_W-1:0] : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_cmd_reg     <= cmd;
            s1_inrange_reg <= ch_inrange;
            s1_addr_reg    <= ch_addr;
            s1_value_reg   <= value;
        end
    end

    // ---------------- channel store ----------------
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [VALUE_W-1:0] wr_data;
    logic [IDX_W-1:0]   addr_b;
    logic [VALUE_W-1:0] ram_rd_a;
    logic [VALUE_W-1:0] ram_rd_b;
    logic [CHANNELS-1:0] store_vld_reg;

    // forwarding of a write landing on the same edge as the read
    logic               vld_a_reg;
    logic               hit_a_reg;
    logic [VALUE_W-1:0] fwd_a_reg;
    logic               vld_b_reg;
    logic               hit_b_reg;
    logic [VALUE_W-1:0] fwd_b_reg;
    logic [VALUE_W-1:0] old_val;
    logic [VALUE_W-1:0] chan_val;

    ppmfg_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (CHANNELS)
    ) u_store (
        .clk     (clk),
        .we      (wr_en),
        .waddr   (wr_addr),
        .wdata   (wr_data),
        .re_a    (in_accept),
        .raddr_a (ch_addr),
        .rdata_a (ram_rd_a),
        .re_b    (1'b1),
        .raddr_b (addr_b),
        .rdata_b (ram_rd_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            store_vld_reg <= '0;
        end
        else if (wr_en)
        begin
            store_vld_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            vld_a_reg <= store_vld_reg[ch_addr];
            hit_a_reg <= wr_en && (wr_addr == ch_addr);
            fwd_a_reg <= wr_data;
        end
        vld_b_reg <= store_vld_reg[addr_b];
        hit_b_reg <= wr_en && (wr_addr == addr_b);
        fwd_b_reg <= wr_data;
    end

    assign old_val  = hit_a_reg ? fwd_a_reg : (vld_a_reg ? ram_rd_a : RESET_PAUSE_WIDTH);
    assign chan_val = hit_b_reg ? fwd_b_reg : (vld_b_reg ? ram_rd_b : RESET_PAUSE_WIDTH);

    // ---------------- slot state ----------------
    logic [SLOT_W-1:0]  slot_reg,  slot_next;
    logic [VALUE_W-1:0] ticks_reg, ticks_next;
    logic [SUM_W-1:0]   sum_reg,   sum_next;
    logic               level_reg, level_next;
    logic               short_reg, short_next;
    logic               start_next;

    logic [SLOT_W-1:0]  slot_inc;
    logic [USED_W-1:0]  used;
    logic               sync_fits;
    logic [VALUE_W-1:0] load_len;
    logic [VALUE_W-1:0] clamped;

    assign slot_inc  = (slot_reg >= LAST_SLOT) ? '0 : slot_reg + 1'b1;
    assign used      = USED_W'(sum_reg) + USED_W'(CHANNELS * cfg_reg.pause_width);
    assign sync_fits = USED_W'(cfg_reg.frame_length) > used;

    always_comb
    begin
        if (slot_inc == LAST_SLOT)
        begin
            load_len = sync_fits ? VALUE_W'(USED_W'(cfg_reg.frame_length) - used)
                                 : VALUE_W'(1);
        end
        else if (slot_inc[0])
        begin
            load_len = chan_val;
        end
        else
        begin
            load_len = cfg_reg.pause_width;
        end
    end

    // max test first, so with min above max a value above max stores max and any other stores min
    always_comb
    begin
        if (s1_value_reg > cfg_reg.max_width)
        begin
            clamped = cfg_reg.max_width;
        end
        else if (s1_value_reg < cfg_reg.min_width)
        begin
            clamped = cfg_reg.min_width;
        end
        else
        begin
            clamped = s1_value_reg;
        end
    end

    always_comb
    begin
        slot_next  = slot_reg;
        ticks_next = ticks_reg;
        sum_next   = sum_reg;
        level_next = level_reg;
        short_next = short_reg;
        start_next = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = s1_addr_reg;
        wr_data    = clamped;
        if (s1_adv)
        begin
            case (s1_cmd_reg)
                CMD_WRITE:
                begin
                    if (s1_inrange_reg)
                    begin
                        wr_en    = 1'b1;
                        sum_next = sum_reg - SUM_W'(old_val) + SUM_W'(clamped);
                    end
                end
                CMD_TICK:
                begin
                    // a slot loaded with zero ends after one tick like length one
                    if (ticks_reg <= VALUE_W'(1))
                    begin
                        slot_next  = slot_inc;
                        level_next = ~level_reg;
                        ticks_next = load_len;
                        start_next = 1'b1;
                        if (slot_inc == LAST_SLOT)
                        begin
                            short_next = ~sync_fits;
                        end
                    end
                    else
                    begin
                        ticks_next = ticks_reg - VALUE_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // prefetch the channel that follows the slot being entered
    logic [SLOT_W-2:0] next_ch;
    assign next_ch = slot_next[SLOT_W-1:1];
    assign addr_b  = ({1'b0, next_ch} < SLOT_W'(CHANNELS)) ? next_ch[IDX_W-1:0] : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg  <= '0;
            ticks_reg <= RESET_PAUSE_WIDTH;
            sum_reg   <= SUM_W'(CHANNELS * RESET_PAUSE_WIDTH);
            level_reg <= 1'b1;
            short_reg <= 1'b0;
        end
        else
        begin
            slot_reg  <= slot_next;
            ticks_reg <= ticks_next;
            sum_reg   <= sum_next;
            level_reg <= level_next;
            short_reg <= short_next;
        end
    end

    // ---------------- result register ----------------
    logic              pin_reg;
    logic [SLOT_W-1:0] idx_reg;
    logic              start_reg;
    logic              flag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            pin_reg   <= level_next;
            idx_reg   <= slot_next;
            start_reg <= start_next;
            flag_reg  <= short_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign pin_level  = pin_reg;
    assign slot_index = idx_reg;
    assign slot_start = start_reg;
    assign sync_short = flag_reg;

    // ---------------- assertions ----------------
    // pin is high exactly in the even (pause) slots
    a_level_parity: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg == ~slot_reg[0])
        else $error("pin level out of step with slot parity");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        slot_reg <= LAST_SLOT)
        else $error("slot counter beyond sync slot");

    // a slot change always comes with a pin toggle
    a_slot_toggle: assert property (@(posedge clk) disable iff (!rst_n)
        slot_reg != slot_next |-> level_reg != level_next)
        else $error("slot advanced without pin toggle");

    a_tick_count: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && s1_cmd_reg == CMD_TICK && ticks_reg > VALUE_W'(1))
        |=> ticks_reg == $past(ticks_reg) - VALUE_W'(1))
        else $error("tick request did not count down");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |=> s1_valid_reg)
        else $error("stalled request lost from input register");

endmodule
